// File: rtl/dwic_pkg.sv
package dwic_pkg;

   localparam int RATE_W      = 24;
   localparam int INDEX_W     = 8;
   localparam int COMPARE0_W  = 16;
   localparam int COMPARE1_W  = 8;
   localparam int PRESCALE_W  = 3;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int HALVE_W     = 4;
   localparam int SHIFT_W     = 3;

   localparam logic [COMPARE0_W-1:0] STEP_LIMIT     = 16'd1280;
   localparam logic [COMPARE0_W-1:0] COMPARE0_RESET = 16'd1136;
   localparam logic [COMPARE1_W-1:0] COMPARE1_RESET = 8'd142;
   localparam logic [SHIFT_W-1:0]    SHIFT_MAX      = 3'd7;

   localparam logic [PRESCALE_W-1:0] PRESCALE_1   = 3'd1;
   localparam logic [PRESCALE_W-1:0] PRESCALE_8   = 3'd2;
   localparam logic [PRESCALE_W-1:0] PRESCALE_64  = 3'd3;
   localparam logic [PRESCALE_W-1:0] PRESCALE_256 = 3'd4;

   typedef enum logic [1:0] {
      CMD_SET_RATE = 2'd0,
      CMD_EVENT_0  = 2'd1,
      CMD_EVENT_1  = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

endpackage

// File: rtl/dual_wavetable_index_clock_core.sv
// Timing core for two wavetable oscillators.
// req channel: one transaction per command. tuser carries command and
// osc_select, tdata carries sample_rate. rsp channel: exactly one
// transaction per request, reporting both indices, the applied compare
// values, the applied prescale code of oscillator 1 and the hard sync flag.
// csr channel: writes wave_sync; always ready, write only while idle.
// Compare events and ignored requests go straight to ST_DONE, which
// registers the result and returns to idle. Rejected rates likewise.
// Set-rate requests run one shared restoring divide/compare unit: one
// quotient bit per cycle over $clog2(CLOCK_HZ+1) numerator bits (24 for
// 16 MHz), a shift search of up to 7 extra quotient bits, then, for
// oscillator 1, halving until the compare value fits in 8 bits.
// One request is in work at a time; req_tready is high only when idle.
// A finished result sits in the rsp register; the next request may be
// accepted meanwhile and waits at its end until that register frees.
// A stalled rsp_tready holds rsp_tvalid and rsp_tdata stable.
// Reset (synchronous, active high) restores the power-up timer values
// and clears indices, pending updates and wave_sync.
module dual_wavetable_index_clock_core #(
   parameter int CLOCK_HZ = 16000000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample_rate[23:0]
   input  logic [dwic_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[1:0], osc_select[2]
   input  logic [dwic_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // index_0[7:0], index_1[15:8], compare_0[31:16], compare_1[39:32],
   // prescale_1[42:40], sync_fired[43], zero fill[47:44]
   output logic [dwic_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_data
);
   import dwic_pkg::*;

   localparam int NUM_W = $clog2(CLOCK_HZ + 1);
   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
   localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(CLOCK_HZ);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_TEST,
      ST_HALVE,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic                   sync_ff, sync_in;
   logic [RATE_W-1:0]      stored_ff [2];
   logic [RATE_W-1:0]      stored_in [2];
   logic [INDEX_W-1:0]     pstep_ff [2];
   logic [INDEX_W-1:0]     pstep_in [2];
   logic [INDEX_W-1:0]     astep_ff [2];
   logic [INDEX_W-1:0]     astep_in [2];
   logic [INDEX_W-1:0]     index_ff [2];
   logic [INDEX_W-1:0]     index_in [2];
   logic                   upd_ff [2];
   logic                   upd_in [2];
   logic [COMPARE0_W-1:0]  pcmp0_ff, pcmp0_in, acmp0_ff, acmp0_in;
   logic [COMPARE1_W-1:0]  pcmp1_ff, pcmp1_in, acmp1_ff, acmp1_in;
   logic [PRESCALE_W-1:0]  ppre_ff, ppre_in, apre_ff, apre_in;
   logic                   fired_ff, fired_in;
   logic                   osc_ff, osc_in;
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic [RATE_W-1:0]      rem_ff, rem_in;
   logic [COMPARE0_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SHIFT_W-1:0]     sh_ff, sh_in;
   logic [HALVE_W-1:0]     h_ff, h_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   cmd_type                cmd;
   logic                   req_osc;
   logic [RATE_W-1:0]      req_rate;
   logic                   div_bit;
   logic [RATE_W:0]        div_cand;
   logic [RATE_W:0]        div_diff;
   logic                   div_qbit;
   logic [INDEX_W-1:0]     step0, step1, next0;

   assign cmd      = cmd_type'(req_tuser[1:0]);
   assign req_osc  = req_tuser[2];
   assign req_rate = req_tdata[RATE_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared restoring divide step: one quotient bit per cycle
   assign div_bit  = (state_ff == ST_DIV) ? NUMERATOR[cnt_ff] : 1'b0;
   assign div_cand = {rem_ff, div_bit};
   assign div_diff = div_cand - {1'b0, rate_ff};
   assign div_qbit = (div_cand >= {1'b0, rate_ff});

   assign step0 = upd_ff[0] ? pstep_ff[0] : astep_ff[0];
   assign step1 = upd_ff[1] ? pstep_ff[1] : astep_ff[1];
   assign next0 = index_ff[0] + step0;

   always_comb begin
      state_in     = state_ff;
      sync_in      = sync_ff;
      stored_in    = stored_ff;
      pstep_in     = pstep_ff;
      astep_in     = astep_ff;
      index_in     = index_ff;
      upd_in       = upd_ff;
      pcmp0_in     = pcmp0_ff;
      acmp0_in     = acmp0_ff;
      pcmp1_in     = pcmp1_ff;
      acmp1_in     = acmp1_ff;
      ppre_in      = ppre_ff;
      apre_in      = apre_ff;
      fired_in     = fired_ff;
      osc_in       = osc_ff;
      rate_in      = rate_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      sh_in        = sh_ff;
      h_in         = h_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         sync_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               fired_in = 1'b0;
               state_in = ST_DONE;
               case (cmd)
                  CMD_SET_RATE: begin
                     if (req_rate != '0 && req_rate != stored_ff[req_osc]) begin
                        stored_in[req_osc] = req_rate;
                        osc_in   = req_osc;
                        rate_in  = req_rate;
                        rem_in   = '0;
                        quo_in   = '0;
                        cnt_in   = CNT_LAST;
                        sh_in    = '0;
                        state_in = ST_DIV;
                     end
                  end
                  CMD_EVENT_0: begin
                     if (upd_ff[0]) begin
                        acmp0_in    = pcmp0_ff;
                        astep_in[0] = pstep_ff[0];
                        upd_in[0]   = 1'b0;
                     end
                     index_in[0] = next0;
                     if (sync_ff && next0 < index_ff[0]) begin
                        index_in[1] = '0;
                        fired_in    = 1'b1;
                     end
                  end
                  CMD_EVENT_1: begin
                     if (upd_ff[1]) begin
                        apre_in     = ppre_ff;
                        astep_in[1] = pstep_ff[1];
                        acmp1_in    = pcmp1_ff;
                        upd_in[1]   = 1'b0;
                     end
                     index_in[1] = index_ff[1] + step1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = div_qbit ? div_diff[RATE_W-1:0] : div_cand[RATE_W-1:0];
            quo_in = {quo_ff[COMPARE0_W-2:0], div_qbit};
            if (cnt_ff == '0) begin
               state_in = ST_TEST;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_TEST: begin
            if (quo_ff > STEP_LIMIT || sh_ff == SHIFT_MAX) begin
               if (quo_ff > STEP_LIMIT) begin
                  pstep_in[osc_ff] = INDEX_W'(1) << sh_ff;
               end
               if (!osc_ff) begin
                  pcmp0_in  = quo_ff;
                  upd_in[0] = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  h_in     = '0;
                  state_in = ST_HALVE;
               end
            end else begin
               // next shift: one more quotient bit with a zero brought down
               rem_in = div_qbit ? div_diff[RATE_W-1:0] : div_cand[RATE_W-1:0];
               quo_in = {quo_ff[COMPARE0_W-2:0], div_qbit};
               sh_in  = sh_ff + 1'b1;
            end
         end
         ST_HALVE: begin
            if (quo_ff[COMPARE0_W-1:COMPARE1_W] != '0) begin
               quo_in = quo_ff >> 1;
               h_in   = h_ff + 1'b1;
            end else begin
               case (h_ff) inside
                  4'd0, 4'd1, 4'd2: begin
                     ppre_in     = PRESCALE_1;
                     pstep_in[1] = pstep_ff[1] >> h_ff;
                  end
                  4'd3, 4'd4, 4'd5: begin
                     ppre_in     = PRESCALE_8;
                     pstep_in[1] = pstep_ff[1] >> (h_ff - 4'd3);
                  end
                  4'd6, 4'd7: begin
                     ppre_in     = PRESCALE_64;
                     pstep_in[1] = pstep_ff[1] >> (h_ff - 4'd6);
                  end
                  default: begin
                     ppre_in = PRESCALE_256;
                  end
               endcase
               pcmp1_in  = quo_ff[COMPARE1_W-1:0];
               upd_in[1] = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, fired_ff, apre_ff, acmp1_ff, acmp0_ff,
                               index_ff[1], index_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sync_ff      <= 1'b0;
         stored_ff    <= '{default: '0};
         pstep_ff     <= '{default: INDEX_W'(1)};
         astep_ff     <= '{default: '0};
         index_ff     <= '{default: '0};
         upd_ff       <= '{default: 1'b0};
         pcmp0_ff     <= COMPARE0_RESET;
         acmp0_ff     <= COMPARE0_RESET;
         pcmp1_ff     <= COMPARE1_RESET;
         acmp1_ff     <= COMPARE1_RESET;
         ppre_ff      <= PRESCALE_64;
         apre_ff      <= PRESCALE_256;
         fired_ff     <= 1'b0;
         osc_ff       <= 1'b0;
         cnt_ff       <= '0;
         sh_ff        <= '0;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sync_ff      <= sync_in;
         stored_ff    <= stored_in;
         pstep_ff     <= pstep_in;
         astep_ff     <= astep_in;
         index_ff     <= index_in;
         upd_ff       <= upd_in;
         pcmp0_ff     <= pcmp0_in;
         acmp0_ff     <= acmp0_in;
         pcmp1_ff     <= pcmp1_in;
         acmp1_ff     <= acmp1_in;
         ppre_ff      <= ppre_in;
         apre_ff      <= apre_in;
         fired_ff     <= fired_in;
         osc_ff       <= osc_in;
         cnt_ff       <= cnt_in;
         sh_ff        <= sh_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff     <= rate_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
